>>> rtl/bbt_pkg.sv
// shared types, byte codes and result kinds of the bencode byte tokenizer
package bbt_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  // queue depth, a power of two of at least 2
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic ERR_BAD_BYTE   = 1'b0;
  localparam logic ERR_OPEN_TOKEN = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT_START,
    MODE_INT_BODY,
    MODE_LEN,
    MODE_PAYLOAD,
    MODE_DISCARD
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] number_value;
    logic [31:0] declared_len;
    logic [7:0]  payload_byte;
    logic        last_of_string;
    logic        error_kind;
    logic        last_of_run;
  } result_t;

  // results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> rtl/bbt_front.sv
// byte classifier and token parser: turns each accepted byte into up to two results
module bbt_front #(
  parameter int LENGTH_BITS = bbt_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bbt_pkg::in_item_t in_data,
  input  logic              room,
  output bbt_pkg::push_t    push
);
  import bbt_pkg::*;

  mode_t                  mode_r, mode_pre, mode_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   frozen_r, frozen_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic                   accept;
  logic [7:0]             c;
  logic                   fin;
  logic                   is_dig;
  logic [3:0]             digit;
  logic [67:0]            acc_ext, acc_sum;
  logic [63:0]            acc_sat;
  logic [LENGTH_BITS+3:0] len_ext, len_sum;
  logic [LENGTH_BITS-1:0] len_sat, rem_dec;
  logic                   prim_v, fin_v, open_tok, silent;
  result_t                prim, fin_res;

  assign accept = in_valid && room;
  assign c      = in_data.data_byte;
  assign fin    = in_data.end_of_input;

  always_comb begin
    is_dig = c inside {[CH_0:CH_9]};
  end
  assign digit = 4'(c - CH_0);

  // times ten plus digit as two shifted adds, saturating on carry out
  assign acc_ext = {4'b0, acc_r};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + 68'(digit);
  assign acc_sat = (|acc_sum[67:64]) ? '1 : acc_sum[63:0];

  assign len_ext = {4'b0, rem_r};
  assign len_sum = (len_ext << 3) + (len_ext << 1) + (LENGTH_BITS+4)'(digit);
  assign len_sat = (|len_sum[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : len_sum[LENGTH_BITS-1:0];

  assign rem_dec = rem_r - LENGTH_BITS'(1);

  // next state: mode after this byte, before the end-of-input reset
  always_comb begin
    mode_pre = mode_r;
    case (mode_r)
      MODE_INT_START, MODE_INT_BODY: begin
        mode_pre = (c == CH_E) ? MODE_IDLE : MODE_INT_BODY;
      end
      MODE_LEN: begin
        if (c == CH_COLON) begin
          mode_pre = (rem_r == '0) ? MODE_IDLE : MODE_PAYLOAD;
        end
      end
      MODE_PAYLOAD: begin
        if (rem_dec == '0) begin
          mode_pre = MODE_IDLE;
        end
      end
      MODE_DISCARD: begin
        mode_pre = MODE_DISCARD;
      end
      default: begin
        if (c == CH_I) begin
          mode_pre = MODE_INT_START;
        end else if (is_dig) begin
          mode_pre = MODE_LEN;
        end else if (c != CH_D && c != CH_E) begin
          mode_pre = MODE_DISCARD;
        end else begin
          mode_pre = MODE_IDLE;
        end
      end
    endcase
    mode_nxt = fin ? MODE_IDLE : mode_pre;
  end

  // results and datapath updates
  always_comb begin
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    frozen_nxt = frozen_r;
    rem_nxt    = rem_r;
    prim_v     = 1'b0;
    prim       = '0;
    case (mode_r)
      MODE_INT_START, MODE_INT_BODY: begin
        if (c == CH_E) begin
          prim_v            = 1'b1;
          prim.token_kind   = KIND_NUMBER;
          prim.number_value = (neg_r && acc_r != '1) ? (64'd0 - acc_r) : acc_r;
          acc_nxt           = '0;
          neg_nxt           = 1'b0;
          frozen_nxt        = 1'b0;
        end else if (mode_r == MODE_INT_START && c == CH_MINUS) begin
          neg_nxt = 1'b1;
        end else if (is_dig && !frozen_r) begin
          acc_nxt = acc_sat;
        end else begin
          frozen_nxt = 1'b1;
        end
      end
      MODE_LEN: begin
        if (c == CH_COLON) begin
          prim_v            = 1'b1;
          prim.token_kind   = KIND_HEADER;
          prim.declared_len = 32'(rem_r);
          frozen_nxt        = 1'b0;
        end else if (is_dig && !frozen_r) begin
          rem_nxt = len_sat;
        end else begin
          frozen_nxt = 1'b1;
        end
      end
      MODE_PAYLOAD: begin
        prim_v              = 1'b1;
        prim.token_kind     = KIND_PAYLOAD;
        prim.payload_byte   = c;
        prim.last_of_string = (rem_dec == '0);
        rem_nxt             = rem_dec;
      end
      MODE_DISCARD: begin
        prim_v = 1'b0;
      end
      default: begin
        if (c == CH_I) begin
          acc_nxt    = '0;
          neg_nxt    = 1'b0;
          frozen_nxt = 1'b0;
        end else if (is_dig) begin
          rem_nxt    = LENGTH_BITS'(digit);
          frozen_nxt = 1'b0;
        end else if (c != CH_D && c != CH_E) begin
          prim_v          = 1'b1;
          prim.token_kind = KIND_ERROR;
          prim.error_kind = ERR_BAD_BYTE;
        end
      end
    endcase

    open_tok = (mode_pre == MODE_INT_START) || (mode_pre == MODE_INT_BODY) ||
               (mode_pre == MODE_LEN) || (mode_pre == MODE_PAYLOAD);
    silent   = (mode_pre == MODE_DISCARD);
    fin_v    = fin && !silent;
    fin_res  = '0;
    if (open_tok) begin
      fin_res.token_kind = KIND_ERROR;
      fin_res.error_kind = ERR_OPEN_TOKEN;
    end else begin
      fin_res.token_kind = KIND_DONE;
    end
    fin_res.last_of_run = 1'b1;

    if (fin) begin
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      frozen_nxt = 1'b0;
      rem_nxt    = '0;
    end

    push = '0;
    if (prim_v) begin
      push.first             = prim;
      push.first.last_of_run = !fin_v;
      push.second            = fin_res;
      push.count             = fin_v ? 2'd2 : 2'd1;
    end else if (fin_v) begin
      push.first = fin_res;
      push.count = 2'd1;
    end
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      frozen_r <= 1'b0;
      rem_r    <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      frozen_r <= frozen_nxt;
      rem_r    <= rem_nxt;
    end
  end

endmodule

>>> rtl/bbt_queue.sv
// short result queue between parser and output stage, up to two writes and one read per cycle
module bbt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bbt_pkg::push_t   push,
  input  logic             pop,
  output logic             room,
  output logic             q_valid,
  output bbt_pkg::result_t q_head
);
  import bbt_pkg::*;

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  // room for the two results a byte can cause
  assign room    = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign q_valid = (count_r != '0);
  assign q_head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/bbt_back.sv
// output register that drains the result queue one transfer per cycle while the output is not stalled
module bbt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  bbt_pkg::result_t q_head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output bbt_pkg::result_t out_data
);
  import bbt_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= q_head;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/bencode_byte_tokenizer.sv
// Bencode byte tokenizer: one byte per transfer in, number, string header, payload byte,
// completed and error tokens out. A byte is taken every cycle while the four-entry result
// queue has room for two results; each byte causes at most two results and the output
// register delivers one per cycle while not stalled, so the sustained rate is one byte
// per cycle for bytes causing zero or one result, and the output port sets the pace
// when closing bytes also end the stream. Each result is written into the queue, then
// into the output register. Reset takes effect at once; there is no clearing pass.
module bencode_byte_tokenizer #(
  parameter int LENGTH_BITS = bbt_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbt_pkg::result_t  out_data
);
  import bbt_pkg::*;

  push_t   push;
  logic    room;
  logic    q_valid;
  logic    pop;
  result_t q_head;

  assign in_stall = !room;

  bbt_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .room    (room),
    .push    (push)
  );

  bbt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .room   (room),
    .q_valid(q_valid),
    .q_head (q_head)
  );

  bbt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // completed and error tokens always close the run of their byte
  a_end_tokens_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == KIND_DONE || out_data.token_kind == KIND_ERROR)
    |-> out_data.last_of_run)
    else $error("end or error token without last_of_run");

  // only number tokens carry a value
  a_number_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind != KIND_NUMBER |-> out_data.number_value == 64'd0)
    else $error("number value on a non-number token");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> bench/testbench.sv
// self-checking testbench for the bencode byte tokenizer: directed and random byte streams
`timescale 1ns / 100ps
module testbench;
  import bbt_pkg::*;

  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_X = 8'h78;
  localparam int RANDOM_BYTES = 1800;
  localparam int MAX_REPORTS = 10;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_CHOPPY} flow_t;

  typedef struct {
    in_item_t item;
    bit       typed;
    int       cnt;
    result_t  first;
    result_t  second;
  } byte_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_item_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  result_t  out_data;

  byte_row_t   byte_rows[$];
  result_t     token_q[$];
  logic [7:0]  stream_q[$];

  // tokenizer state as the bench sees it
  mode_t       pmode = MODE_IDLE;
  logic [63:0] acc = '0;
  logic        neg = 1'b0;
  logic        frozen = 1'b0;
  logic [31:0] remaining = '0;

  int checked = 0;
  int mismatches = 0;
  int n_numbers = 0;
  int n_headers = 0;
  int n_payload = 0;
  int n_done = 0;
  int n_errors = 0;
  int streams = 0;

  bencode_byte_tokenizer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic bit is_dig(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic result_t tok(logic [2:0] kind, logic [63:0] num, logic [31:0] len,
                                  logic [7:0] pb, logic ls, logic ek, logic lr);
    result_t r;
    r.token_kind = kind;
    r.number_value = num;
    r.declared_len = len;
    r.payload_byte = pb;
    r.last_of_string = ls;
    r.error_kind = ek;
    r.last_of_run = lr;
    return r;
  endfunction

  // advances the state by one byte; queues the tokens it causes when keep is set
  task automatic tokenize(input in_item_t it, input bit keep);
    result_t     res [2];
    int          cnt;
    logic [7:0]  c;
    logic [63:0] d, v, lv;
    logic        open, closed, silent;
    c = it.data_byte;
    d = 64'(c) - 64'(CH_0);
    cnt = 0;
    open = 1'b0;
    closed = 1'b0;
    silent = 1'b0;
    case (pmode)
      MODE_INT_START, MODE_INT_BODY: begin
        if (c == CH_E) begin
          v = acc;
          if (neg && v != SAT64) v = 64'd0 - v;
          res[cnt] = tok(KIND_NUMBER, v, '0, '0, 1'b0, 1'b0, 1'b0);
          cnt++;
          acc = '0;
          neg = 1'b0;
          frozen = 1'b0;
          pmode = MODE_IDLE;
        end else begin
          if (pmode == MODE_INT_START && c == CH_MINUS) begin
            neg = 1'b1;
          end else if (is_dig(c) && !frozen) begin
            if (acc > (SAT64 - d) / 64'd10) acc = SAT64;
            else acc = acc * 64'd10 + d;
          end else begin
            frozen = 1'b1;
          end
          pmode = MODE_INT_BODY;
          open = 1'b1;
        end
      end
      MODE_LEN: begin
        if (c == CH_COLON) begin
          res[cnt] = tok(KIND_HEADER, '0, remaining, '0, 1'b0, 1'b0, 1'b0);
          cnt++;
          frozen = 1'b0;
          if (remaining == 0) begin
            pmode = MODE_IDLE;
          end else begin
            pmode = MODE_PAYLOAD;
            open = 1'b1;
          end
        end else begin
          if (is_dig(c) && !frozen) begin
            lv = {32'd0, remaining} * 64'd10 + d;
            remaining = (lv > LEN_MAX) ? LEN_MAX[31:0] : lv[31:0];
          end else begin
            frozen = 1'b1;
          end
          open = 1'b1;
        end
      end
      MODE_PAYLOAD: begin
        remaining = remaining - 32'd1;
        res[cnt] = tok(KIND_PAYLOAD, '0, '0, c, remaining == 0, 1'b0, 1'b0);
        cnt++;
        if (remaining == 0) pmode = MODE_IDLE;
        else open = 1'b1;
      end
      MODE_DISCARD: begin
        silent = 1'b1;
      end
      default: begin
        if (c == CH_D || c == CH_E) begin
          // skipped between tokens
        end else if (c == CH_I) begin
          acc = '0;
          neg = 1'b0;
          frozen = 1'b0;
          pmode = MODE_INT_START;
          open = 1'b1;
        end else if (is_dig(c)) begin
          remaining = d[31:0];
          frozen = 1'b0;
          pmode = MODE_LEN;
          open = 1'b1;
        end else begin
          res[cnt] = tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_BYTE, 1'b0);
          cnt++;
          pmode = MODE_DISCARD;
          silent = 1'b1;
        end
      end
    endcase
    if (it.end_of_input) begin
      if (!silent) begin
        if (open) begin
          res[cnt] = tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_OPEN_TOKEN, 1'b0);
          cnt++;
        end else begin
          closed = 1'b1;
        end
      end
      if (closed) begin
        res[cnt] = tok(KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        cnt++;
      end
      pmode = MODE_IDLE;
      acc = '0;
      neg = 1'b0;
      frozen = 1'b0;
      remaining = '0;
    end
    if (cnt > 0) res[cnt - 1].last_of_run = 1'b1;
    if (keep) begin
      for (int k = 0; k < cnt; k++) token_q.push_back(res[k]);
    end
  endtask

  function automatic void add_typed(logic [7:0] b, logic fin, int cnt, result_t a, result_t z);
    byte_row_t r;
    r.item.data_byte = b;
    r.item.end_of_input = fin;
    r.typed = 1'b1;
    r.cnt = cnt;
    r.first = a;
    r.second = z;
    byte_rows.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic fin);
    add_typed(b, fin, 0, '0, '0);
    byte_rows[$].typed = 1'b0;
  endfunction

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++) stream_q.push_back(s[k]);
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // one stream of mostly well-formed tokens, sometimes cut short or salted with noise
  task automatic add_stream();
    logic [7:0] j;
    int         pick, len, keep_n;
    bit         stop;
    stream_q.delete();
    stop = 1'b0;
    for (int t = $urandom_range(1, 6); t > 0 && !stop; t--) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        stream_q.push_back(pick[0] ? CH_D : CH_E);
      end else if (pick < 10) begin
        stream_q.push_back(CH_I);
        if ($urandom_range(0, 2) == 0) stream_q.push_back(CH_MINUS);
        case ($urandom_range(0, 5))
          0: ;
          1: begin
            case ($urandom_range(0, 2))
              0: push_text("18446744073709551615");
              1: push_text("18446744073709551616");
              default: push_text("99999999999999999999999");
            endcase
          end
          default: push_text(rand_digits($urandom_range(1, 20)));
        endcase
        if ($urandom_range(0, 5) == 0) begin
          j = 8'($urandom_range(0, 255));
          if (j == CH_E) j = CH_X;
          stream_q.push_back(j);
          push_text(rand_digits($urandom_range(0, 3)));
        end
        stream_q.push_back(CH_E);
      end else if (pick < 17) begin
        len = $urandom_range(0, 6);
        if ($urandom_range(0, 5) == 0) stream_q.push_back(CH_0);
        push_text($sformatf("%0d", len));
        if ($urandom_range(0, 5) == 0) begin
          // digits after a stray byte in the length are ignored
          j = 8'($urandom_range(0, 255));
          if (is_dig(j) || j == CH_COLON) j = CH_PLUS;
          stream_q.push_back(j);
          push_text(rand_digits($urandom_range(0, 2)));
        end
        stream_q.push_back(CH_COLON);
        repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 17) begin
        case ($urandom_range(0, 2))
          0: push_text("4294967295");
          1: push_text("4294967296");
          default: push_text(rand_digits($urandom_range(10, 12)));
        endcase
        stream_q.push_back(CH_COLON);
        repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(0, 255)));
        stop = 1'b1;
      end else begin
        stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      keep_n = $urandom_range(1, stream_q.size());
      while (stream_q.size() > keep_n) void'(stream_q.pop_back());
    end
    foreach (stream_q[k]) add_byte(stream_q[k], k == stream_q.size() - 1);
    streams++;
  endtask

  // result side: stall pattern and checking
  flow_t flow = FLOW_FREE;
  int    flow_left = 0;

  always @(posedge clk) begin
    if (flow_left == 0) begin
      flow = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(16, 200);
    end else begin
      flow_left--;
    end
    case (flow)
      FLOW_FREE: out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= flow_left[3];
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected token transfer: kind %0d num %h len %0d byte %h",
                   out_data.token_kind, out_data.number_value, out_data.declared_len,
                   out_data.payload_byte);
      end else begin
        want = token_q.pop_front();
        checked++;
        if (out_data.token_kind !== want.token_kind ||
            out_data.number_value !== want.number_value ||
            out_data.declared_len !== want.declared_len ||
            out_data.payload_byte !== want.payload_byte ||
            out_data.last_of_string !== want.last_of_string ||
            out_data.error_kind !== want.error_kind ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("token %0d mismatch: expected kind %0d num %h len %0d byte %h ls %b ek %b lr %b",
                     checked, want.token_kind, want.number_value, want.declared_len,
                     want.payload_byte, want.last_of_string, want.error_kind, want.last_of_run);
            $display("  got kind %0d num %h len %0d byte %h ls %b ek %b lr %b",
                     out_data.token_kind, out_data.number_value, out_data.declared_len,
                     out_data.payload_byte, out_data.last_of_string, out_data.error_kind,
                     out_data.last_of_run);
          end
        end
        case (want.token_kind)
          KIND_NUMBER: n_numbers++;
          KIND_HEADER: n_headers++;
          KIND_PAYLOAD: n_payload++;
          KIND_DONE: n_done++;
          default: n_errors++;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d tokens still pending", token_q.size());
    $display("FAIL bencode_byte_tokenizer");
    $finish;
  end

  initial begin
    int dir_rows, mid, gap, burst_left;

    // directed rows
    add_typed(8'h00, 1'b0, 1, tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_BYTE, 1'b1), '0);
    add_typed(8'hff, 1'b1, 0, '0, '0);
    add_typed(CH_D, 1'b0, 0, '0, '0);
    add_byte(CH_I, 1'b0);
    add_byte(CH_MINUS, 1'b0);
    add_byte(CH_0 + 8'd4, 1'b0);
    add_byte(CH_E, 1'b0);
    add_byte(CH_I, 1'b0);
    add_typed(CH_E, 1'b1, 2, tok(KIND_NUMBER, '0, '0, '0, 1'b0, 1'b0, 1'b0),
              tok(KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1));
    add_byte(CH_0, 1'b0);
    add_typed(CH_COLON, 1'b0, 1, tok(KIND_HEADER, '0, '0, '0, 1'b0, 1'b0, 1'b1), '0);
    add_byte(CH_0 + 8'd3, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_typed(8'h5a, 1'b0, 1, tok(KIND_PAYLOAD, '0, '0, 8'h5a, 1'b1, 1'b0, 1'b1), '0);
    add_typed(CH_E, 1'b1, 1, tok(KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1), '0);
    add_typed(CH_0 + 8'd1, 1'b1, 1, tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_OPEN_TOKEN, 1'b1), '0);
    add_byte(CH_I, 1'b0);
    add_byte(CH_X, 1'b0);
    add_byte(CH_0 + 8'd5, 1'b0);
    add_byte(CH_E, 1'b0);
    add_byte(CH_0 + 8'd2, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_typed(8'h7a, 1'b1, 2, tok(KIND_PAYLOAD, '0, '0, 8'h7a, 1'b0, 1'b0, 1'b0),
              tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_OPEN_TOKEN, 1'b1));
    add_typed(CH_I, 1'b1, 1, tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_OPEN_TOKEN, 1'b1), '0);
    add_typed(CH_COLON, 1'b1, 1, tok(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_BYTE, 1'b1), '0);
    dir_rows = byte_rows.size();
    while (byte_rows.size() - dir_rows < RANDOM_BYTES) add_stream();
    mid = dir_rows + (byte_rows.size() - dir_rows) / 2;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = 0;
    for (int i = 0; i < byte_rows.size(); i++) begin
      if (i == dir_rows || i == mid) begin
        // hold off until every predicted token has come back
        in_valid <= 1'b0;
        do @(posedge clk); while (token_q.size() != 0);
        burst_left = 0;
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid <= 1'b1;
      in_data <= byte_rows[i].item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      // transfer accepted at this edge
      tokenize(byte_rows[i].item, !byte_rows[i].typed);
      if (byte_rows[i].typed) begin
        if (byte_rows[i].cnt > 0) token_q.push_back(byte_rows[i].first);
        if (byte_rows[i].cnt > 1) token_q.push_back(byte_rows[i].second);
      end
      burst_left--;
    end
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes: %0d directed, the rest in %0d random streams",
             byte_rows.size(), dir_rows, streams);
    $display("checked %0d tokens: %0d numbers, %0d headers, %0d payload, %0d completed, %0d errors",
             checked, n_numbers, n_headers, n_payload, n_done, n_errors);
    if (mismatches == 0) begin
      $display("PASS bencode_byte_tokenizer");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL bencode_byte_tokenizer");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbt_pkg.sv
rtl/bbt_front.sv
rtl/bbt_queue.sv
rtl/bbt_back.sv
rtl/bencode_byte_tokenizer.sv
bench/testbench.sv
